// ===== src/frot_pkg.sv =====
// shared types, constants and codes for the frame rotator
package frot_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);

  localparam int DIM_W  = 7;
  localparam int PIX_W  = 24;
  localparam int MODE_W = 2;
  localparam int REG_W  = 2;

  localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [REG_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_W-1:0] REG_ROTATE_MODE  = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CW  = 2'd0,
    MODE_CCW = 2'd1,
    MODE_180 = 2'd2
  } rot_mode_t;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel_rgb;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] rotated_rgb;
    logic             frame_last;
  } out_item_t;

  // effective frame settings, sizes already clamped
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [MODE_W-1:0] mode;
  } frame_cfg_t;

  // one store access handed from the address generator
  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
    logic              last;
  } store_req_t;

endpackage

// ===== src/frot_cfg.sv =====
// configuration registers with size clamping and frame restart
module frot_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [frot_pkg::REG_W-1:0] cfg_index,
  input  logic [frot_pkg::DIM_W-1:0] cfg_data,
  output frot_pkg::frame_cfg_t      cfg,
  output logic                      restart
);
  import frot_pkg::*;

  logic             wr_fire;
  logic [DIM_W-1:0] clamp_w;
  logic [DIM_W-1:0] clamp_h;

  assign cfg_ready = 1'b1;
  assign wr_fire   = cfg_valid && cfg_ready;

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (cfg_data == '0) begin
      clamp_w = DIM_W'(1);
      clamp_h = DIM_W'(1);
    end else begin
      clamp_w = (cfg_data > DIM_MAX_W) ? DIM_MAX_W : cfg_data;
      clamp_h = (cfg_data > DIM_MAX_H) ? DIM_MAX_H : cfg_data;
    end
  end

  assign restart = wr_fire && (cfg_index == REG_IMAGE_WIDTH ||
                               cfg_index == REG_IMAGE_HEIGHT ||
                               cfg_index == REG_ROTATE_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= DIM_W'(64);
      cfg.height <= DIM_W'(64);
      cfg.mode   <= MODE_CW;
    end else if (wr_fire) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.width  <= clamp_w;
        REG_IMAGE_HEIGHT: cfg.height <= clamp_h;
        REG_ROTATE_MODE:  cfg.mode   <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/frot_addr.sv =====
// load and read position counters and rotated address generation
module frot_addr (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   restart,
  input  frot_pkg::frame_cfg_t   cfg,
  input  logic                   accept,
  input  frot_pkg::in_item_t     item,
  output frot_pkg::store_req_t   req
);
  import frot_pkg::*;

  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic [ADDR_W-1:0]   col_term;   // col * height
  logic [ADDR_W-1:0]   lin;        // row * width + col
  logic [ADDR_W-1:0]   read_index;

  logic [2*DIM_W-1:0]  n_full;
  logic [2*DIM_W:0]    n_minus1;
  logic [ADDR_W-1:0]   last_idx;
  logic [ADDR_W-1:0]   base_cw;
  logic [ADDR_W-1:0]   wr_addr;
  logic                col_wrap;
  logic                row_wrap;
  logic                is_load;

  assign n_full   = cfg.width * cfg.height;
  assign n_minus1 = {1'b0, n_full} - (2*DIM_W+1)'(1);
  assign last_idx = n_minus1[ADDR_W-1:0];

  // clockwise position: c*h + (h-1-r)
  assign base_cw = col_term + ADDR_W'(cfg.height) - ADDR_W'(1) - ADDR_W'(row);

  always_comb begin
    case (cfg.mode)
      MODE_CCW: wr_addr = last_idx - base_cw;
      MODE_180: wr_addr = last_idx - lin;
      default:  wr_addr = base_cw;
    endcase
  end

  assign is_load  = (item.operation == OP_LOAD);
  assign col_wrap = (DIM_W'(col) == cfg.width - DIM_W'(1));
  assign row_wrap = (DIM_W'(row) == cfg.height - DIM_W'(1));

  always_comb begin
    req.op    = item.operation;
    req.addr  = is_load ? wr_addr : read_index;
    req.pixel = item.pixel_rgb;
    req.last  = (read_index == last_idx);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col        <= '0;
      row        <= '0;
      col_term   <= '0;
      lin        <= '0;
      read_index <= '0;
    end else if (accept) begin
      if (is_load) begin
        if (col_wrap) begin
          col      <= '0;
          col_term <= '0;
          if (row_wrap) begin
            row <= '0;
            lin <= '0;
          end else begin
            row <= row + ROW_W'(1);
            lin <= lin + ADDR_W'(1);
          end
        end else begin
          col      <= col + COL_W'(1);
          col_term <= col_term + ADDR_W'(cfg.height);
          lin      <= lin + ADDR_W'(1);
        end
      end else begin
        read_index <= req.last ? '0 : read_index + ADDR_W'(1);
      end
    end
  end

endmodule

// ===== src/frot_store.sv =====
// request register, frame memory and registered result stage
module frot_store (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  frot_pkg::store_req_t req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output frot_pkg::out_item_t  out_data
);
  import frot_pkg::*;

  logic [PIX_W-1:0] mem [STORE_DEPTH];

  logic       s1_valid;
  store_req_t s1;
  logic       out_free;
  logic       s1_done;
  logic       rd_fire;
  logic       req_fire;

  assign out_free  = !out_valid || !out_stall;
  // loads retire regardless of the output; reads need a free result slot
  assign s1_done   = s1_valid && (s1.op == OP_LOAD || out_free);
  assign rd_fire   = s1_valid && s1.op == OP_READ && out_free;
  assign req_stall = s1_valid && !s1_done;
  assign req_fire  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (rd_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1 <= req;
    end
    if (s1_valid && s1.op == OP_LOAD) begin
      mem[s1.addr] <= s1.pixel;
    end
    if (rd_fire) begin
      out_data.rotated_rgb <= mem[s1.addr];
      out_data.frame_last  <= s1.last;
    end
  end

endmodule

// ===== src/frame_rotator_90_180.sv =====
// top level of the frame rotator: config block, address generator, frame store
//
// usage
//   input channel (in_valid / in_stall / in_data) carries load and read items;
//   a load writes the next source pixel, in raster order, to its rotated spot
//   output channel (out_valid / out_stall / out_data) returns one pixel per
//   read item in rotated raster order, frame_last set on the final pixel
//   config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) sets width,
//   height and mode; a write to any of these restarts the load and read
//   counters, frame memory keeps its contents; cfg_ready is always high
// timing
//   one item per cycle when in_stall is low; the frame memory port takes one
//   access per cycle and the counters step once per transfer
//   out_valid rises once the read has passed the request and output registers
// reset
//   sync active-high rst clears counters and valid flags and sets 64x64,
//   clockwise; memory contents are not cleared and need no clearing pass
// stall
//   a stalled result holds in the output register; one more item is taken
//   into the request register, after which in_stall rises until the output
//   drains (loads keep retiring while a result waits)
module frame_rotator_90_180 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  frot_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output frot_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [frot_pkg::REG_W-1:0] cfg_index,
  input  logic [frot_pkg::DIM_W-1:0] cfg_data
);
  import frot_pkg::*;

  frame_cfg_t cfg;
  store_req_t req;
  logic       restart;
  logic       in_accept;

  // an item transfer advances the address counters
  assign in_accept = in_valid && !in_stall;

  // register file, clamps sizes and flags a frame restart
  frot_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .restart   (restart)
  );

  // incremental counters give the rotated write address or the read address
  frot_addr u_addr (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .cfg     (cfg),
    .accept  (in_accept),
    .item    (in_data),
    .req     (req)
  );

  // request register, memory access and result register
  frot_store u_store (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req_stall (in_stall),
    .req       (req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
